>>> hw/rtl/prefix_trie_insert_lookup_unit_assert.svh
// Assertion macros for the prefix trie unit.
// Used by the top level; no other dependencies.
`ifndef PREFIX_TRIE_INSERT_LOOKUP_UNIT_ASSERT_SVH
`define PREFIX_TRIE_INSERT_LOOKUP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PTIL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PTIL_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PTIL_ASSERT(lbl, clk, rst, prop, msg)
`define PTIL_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> hw/rtl/ptil_pkg.sv
// Shared constants and controller/datapath interface types for the prefix trie unit.
// No dependencies.
`default_nettype none
package ptil_pkg;
   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int FREE_W        = $clog2(NODE_COUNT + 1);
   localparam int LINK_DEPTH    = NODE_COUNT * ALPHABET_SIZE;
   localparam int LINK_AW       = $clog2(LINK_DEPTH);
   localparam int CMD_W         = 2;
   localparam int LETTER_W      = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic link_check;
      logic mark_read;
      logic mark_check;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_req;
      logic req_last;
      logic item_last;
   } dp_status_type;
endpackage
`default_nettype wire

>>> hw/rtl/prefix_trie_insert_lookup_unit.sv
// A letter item that is not last passes through the link check before the next item is taken;
// an item that walks no letter leaves the controller idle. A last item goes through the mark
// read and mark check states, and the result strobe is registered from the mark check; no new
// item is taken until idle again. Results cannot be stalled. Throughput is bounded by the child
// table read/write per letter. Reset: synchronous; a clearing pass over every child table entry
// (and the marks) follows, during which busy stays high.
`default_nettype none
`include "prefix_trie_insert_lookup_unit_assert.svh"
module prefix_trie_insert_lookup_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ptil_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [ptil_pkg::LETTER_W-1:0] req_letter,
   input  wire logic                          req_no_letter,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic                               rsp_pool_full
);
   ptil_pkg::ctrl_cmd_type  cmd;
   ptil_pkg::dp_status_type status;

   ptil_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ptil_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_cmd),
      .req_letter    (req_letter),
      .req_no_letter (req_no_letter),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_found     (rsp_found),
      .rsp_pool_full (rsp_pool_full)
   );

   `PTIL_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "controller issued two commands")
   `PTIL_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")
   `PTIL_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result repeated")
   `PTIL_ASSERT_NEVER(a_accept_clear, clock, reset, cmd.accept && cmd.clear_step,
                      "transaction accepted during clearing pass")
endmodule
`default_nettype wire

>>> hw/rtl/ptil_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ptil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> hw/rtl/ptil_ctrl.sv
// Sequencing state machine for the prefix trie unit.
// Depends on ptil_pkg.
`default_nettype none
module ptil_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire ptil_pkg::dp_status_type status,
   output ptil_pkg::ctrl_cmd_type       cmd,
   output logic                         busy
);
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_LINK    = 3'd2;
   localparam logic [2:0] S_MARK_RD = 3'd3;
   localparam logic [2:0] S_MARK    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (status.walk_req) begin
                  state_in = S_LINK;
               end else if (status.req_last) begin
                  state_in = S_MARK_RD;
               end
            end
         end
         S_LINK: begin
            cmd.link_check = 1'b1;
            state_in = status.item_last ? S_MARK_RD : S_IDLE;
         end
         S_MARK_RD: begin
            cmd.mark_read = 1'b1;
            state_in = S_MARK;
         end
         S_MARK: begin
            cmd.mark_check = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

>>> hw/rtl/ptil_dp.sv
// Datapath: child link table, word end marks, walk state and result registers.
// Depends on ptil_pkg and ptil_ram.
`default_nettype none
module ptil_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ptil_pkg::ctrl_cmd_type              cmd,
   output ptil_pkg::dp_status_type                  status,
   input  wire logic [ptil_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [ptil_pkg::LETTER_W-1:0]       req_letter,
   input  wire logic                                req_no_letter,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   output logic                                     rsp_found,
   output logic                                     rsp_pool_full
);
   logic [ptil_pkg::CMD_W-1:0]   cmd_ff;
   logic                         last_ff;
   logic [ptil_pkg::LINK_AW-1:0] slot_ff;
   logic [ptil_pkg::NODE_W-1:0]  cur_ff, cur_in;
   logic                         miss_ff, miss_in;
   logic                         exh_ff, exh_in;
   logic [ptil_pkg::FREE_W-1:0]  free_ff, free_in;
   logic [ptil_pkg::LINK_AW-1:0] clr_cnt_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic                         rsp_pool_full_ff;

   logic [ptil_pkg::LINK_AW-1:0] slot_new;
   logic                         letter_ok;
   logic                         walk_req;
   logic                         link_wr_en;
   logic [ptil_pkg::LINK_AW-1:0] link_wr_addr;
   logic [ptil_pkg::NODE_W-1:0]  link_wr_data;
   logic [ptil_pkg::NODE_W-1:0]  child;
   logic                         alloc;
   logic                         mark_clr;
   logic                         mark_set;
   logic                         mark_wr_en;
   logic [ptil_pkg::NODE_W-1:0]  mark_wr_addr;
   logic                         mark_bit;
   logic                         found_in;

   assign slot_new = ptil_pkg::LINK_AW'(cur_ff) * ptil_pkg::LINK_AW'(ptil_pkg::ALPHABET_SIZE)
                   + ptil_pkg::LINK_AW'(req_letter);
   assign letter_ok = int'(req_letter) < ptil_pkg::ALPHABET_SIZE;
   assign walk_req  = !req_no_letter && !miss_ff && letter_ok;

   assign status.clear_done = (clr_cnt_ff == ptil_pkg::LINK_AW'(ptil_pkg::LINK_DEPTH - 1));
   assign status.walk_req   = walk_req;
   assign status.req_last   = req_last;
   assign status.item_last  = last_ff;

   assign alloc = cmd.link_check && (child == '0) && (cmd_ff == ptil_pkg::CMD_INSERT)
                && (free_ff < ptil_pkg::FREE_W'(ptil_pkg::NODE_COUNT));

   assign link_wr_en   = cmd.clear_step || alloc;
   assign link_wr_addr = cmd.clear_step ? clr_cnt_ff : slot_ff;
   assign link_wr_data = cmd.clear_step ? '0 : free_ff[ptil_pkg::NODE_W-1:0];

   ptil_ram #(.WIDTH(ptil_pkg::NODE_W), .DEPTH(ptil_pkg::LINK_DEPTH)) u_links (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (cmd.accept && walk_req),
      .rd_addr (slot_new),
      .rd_data (child)
   );

   assign mark_clr     = cmd.clear_step && (int'(clr_cnt_ff) < ptil_pkg::NODE_COUNT);
   assign mark_set     = cmd.mark_check && (cmd_ff == ptil_pkg::CMD_INSERT) && !miss_ff;
   assign mark_wr_en   = mark_clr || mark_set;
   assign mark_wr_addr = mark_clr ? clr_cnt_ff[ptil_pkg::NODE_W-1:0] : cur_ff;

   ptil_ram #(.WIDTH(1), .DEPTH(ptil_pkg::NODE_COUNT)) u_marks (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (!mark_clr),
      .rd_en   (cmd.mark_read),
      .rd_addr (cur_ff),
      .rd_data (mark_bit)
   );

   always_comb begin
      cur_in   = cur_ff;
      miss_in  = miss_ff;
      exh_in   = exh_ff;
      free_in  = free_ff;
      found_in = 1'b0;
      if (cmd.accept && !req_no_letter && !miss_ff && !letter_ok) begin
         miss_in = 1'b1;
      end
      if (cmd.link_check) begin
         if (child != '0) begin
            cur_in = child;
         end else if (cmd_ff != ptil_pkg::CMD_INSERT) begin
            miss_in = 1'b1;
         end else if (alloc) begin
            cur_in  = free_ff[ptil_pkg::NODE_W-1:0];
            free_in = free_ff + 1'b1;
         end else begin
            exh_in  = 1'b1;
            miss_in = 1'b1;
         end
      end
      if (cmd.mark_check) begin
         case (cmd_ff)
            ptil_pkg::CMD_INSERT: found_in = !miss_ff;
            ptil_pkg::CMD_EXACT:  found_in = !miss_ff && mark_bit;
            default:              found_in = !miss_ff;
         endcase
         cur_in  = '0;
         miss_in = 1'b0;
         exh_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         miss_ff      <= 1'b0;
         exh_ff       <= 1'b0;
         free_ff      <= ptil_pkg::FREE_W'(1);
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         miss_ff      <= miss_in;
         exh_ff       <= exh_in;
         free_ff      <= free_in;
         rsp_valid_ff <= cmd.mark_check;
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_cmd;
         last_ff <= req_last;
         slot_ff <= slot_new;
      end
      if (cmd.mark_check) begin
         rsp_found_ff     <= found_in;
         rsp_pool_full_ff <= exh_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_pool_full = rsp_pool_full_ff;
endmodule
`default_nettype wire
